// ===== src/assert_macros.svh =====
// assertion macros shared by the lzss decompressor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LZD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lzd: same-cycle check failed");

// next-cycle implication, disabled during reset
`define LZD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lzd: next-cycle check failed");

`endif

// ===== src/lzd_pkg.sv =====
// package with constants and types of the lzss window decompressor
`timescale 1ns / 1ps

package lzd_pkg;

	// window geometry
	localparam int WindowDepth = 4096;
	// write position starts this many entries below the window top (0xfee)
	localparam int StartGap    = 18;

	// stream format
	localparam int ByteW    = 8;
	localparam int LenW     = 24;
	localparam int FlagBits = 8;
	localparam int LenBias  = 3;
	// longest run of one token: 15 + 3 bytes
	localparam int RunW     = 5;

	// one byte towards the output register
	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] data;
		logic             last;
	} lzd_emit_t;

	// controller status
	typedef struct packed {
		logic clearing;
		logic finished;
	} lzd_stat_t;

endpackage

// ===== src/lzd_window_ram.sv =====
// history window memory: one write port, one registered read port, read-first
`timescale 1ns / 1ps

module lzd_window_ram import lzd_pkg::*; #(
	parameter int DEPTH = WindowDepth,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [ByteW-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [ByteW-1:0] rdata
);

	logic [ByteW-1:0] mem [DEPTH];
	logic [ByteW-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/lzd_ctrl.sv =====
// token parser, copy sequencer and window clearing around the history memory
`timescale 1ns / 1ps

module lzd_ctrl import lzd_pkg::*; #(
	parameter int WINDOW_DEPTH = WindowDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [LenW-1:0]  out_length,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ByteW-1:0] in_byte,
	input  logic             slot_free,
	output lzd_emit_t        emit,
	output lzd_stat_t        stat
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam logic [AW-1:0] WinStart = AW'(WINDOW_DEPTH - StartGap);
	localparam logic [AW-1:0] WinLast  = AW'(WINDOW_DEPTH - 1);

	typedef enum logic [1:0] {
		PH_FLAG,
		PH_DATA,
		PH_LEN
	} phase_t;

	// parser and window state
	phase_t            phase_q;
	logic [ByteW-1:0]  ctrl_bits_q;
	logic [3:0]        bits_left_q;
	logic [ByteW-1:0]  off_lo_q;
	logic [AW-1:0]     wp_q;
	logic [LenW-1:0]   out_len_q;
	logic [LenW-1:0]   count_q;
	logic              finished_q;
	logic              clr_q;
	logic [AW-1:0]     clr_addr_q;

	// copy sequencer
	logic              pend_s1;
	logic              lit_s1;
	logic [ByteW-1:0]  lit_byte_s1;
	logic              fwd_s1;
	logic [ByteW-1:0]  fwd_byte_s1;
	logic [AW-1:0]     src_q;
	logic [RunW-1:0]   remain_q;

	// memory port signals
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [ByteW-1:0]  ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [ByteW-1:0]  ram_rdata;

	logic              accept;
	logic              start_match;
	logic              emit_go;
	logic              hit_end;
	logic              more;
	logic              fwd_nx;
	logic [LenW-1:0]   count_nx;
	logic [ByteW-1:0]  emit_byte;
	logic [AW-1:0]     match_off;
	logic [RunW-1:0]   match_cnt;
	logic [3:0]        left_nx;
	phase_t            phase_after_bit;

	// input handshake and token decode
	assign in_ready    = !clr_q && !pend_s1;
	assign accept      = in_valid && in_ready;
	assign start_match = accept && !finished_q && (phase_q == PH_LEN);
	assign match_off   = AW'({in_byte[7:4], off_lo_q});
	assign match_cnt   = RunW'(in_byte[3:0]) + RunW'(LenBias);

	// control bit bookkeeping
	assign left_nx         = (bits_left_q == 4'd0) ? 4'd0 : bits_left_q - 4'd1;
	assign phase_after_bit = (left_nx == 4'd0) ? PH_FLAG : PH_DATA;

	// byte leaving this cycle
	assign emit_byte = lit_s1 ? lit_byte_s1 : (fwd_s1 ? fwd_byte_s1 : ram_rdata);
	assign emit_go   = pend_s1 && slot_free;
	assign count_nx  = count_q + LenW'(1);
	assign hit_end   = (count_nx == out_len_q);
	assign more      = emit_go && !hit_end && (remain_q > RunW'(1));

	// memory ports; clearing and copying never overlap
	assign ram_we    = clr_q || emit_go;
	assign ram_waddr = clr_q ? clr_addr_q : wp_q;
	assign ram_wdata = clr_q ? '0 : emit_byte;
	assign ram_re    = start_match || more;
	assign ram_raddr = start_match ? match_off : src_q;
	// a read of the entry being written gets the new byte
	assign fwd_nx    = ram_we && (ram_waddr == ram_raddr);

	assign emit.valid    = emit_go;
	assign emit.data     = emit_byte;
	assign emit.last     = hit_end;
	assign stat.clearing = clr_q;
	assign stat.finished = finished_q;

	lzd_window_ram #(
		.DEPTH (WINDOW_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// payload of the copy sequencer
	always_ff @(posedge clk) begin
		if (accept && !finished_q && (phase_q == PH_DATA) && ctrl_bits_q[0]) begin
			lit_byte_s1 <= in_byte;
		end
		if (ram_re) begin
			fwd_byte_s1 <= ram_wdata;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FLAG;
			ctrl_bits_q <= '0;
			bits_left_q <= '0;
			off_lo_q    <= '0;
			wp_q        <= WinStart;
			out_len_q   <= '0;
			count_q     <= '0;
			finished_q  <= 1'b1;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			pend_s1     <= 1'b0;
			lit_s1      <= 1'b0;
			fwd_s1      <= 1'b0;
			src_q       <= '0;
			remain_q    <= '0;
		end else if (cfg_valid) begin
			// restart: new length, window cleared again
			out_len_q   <= out_length;
			finished_q  <= (out_length == '0);
			phase_q     <= PH_FLAG;
			ctrl_bits_q <= '0;
			bits_left_q <= '0;
			off_lo_q    <= '0;
			wp_q        <= WinStart;
			count_q     <= '0;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			pend_s1     <= 1'b0;
			lit_s1      <= 1'b0;
			fwd_s1      <= 1'b0;
		end else begin
			// clearing sweep, one entry a cycle
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == WinLast) begin
					clr_q <= 1'b0;
				end
			end

			// token parse on each accepted byte
			if (accept && !finished_q) begin
				case (phase_q)
					PH_DATA: begin
						if (ctrl_bits_q[0]) begin
							pend_s1     <= 1'b1;
							lit_s1      <= 1'b1;
							remain_q    <= RunW'(1);
							ctrl_bits_q <= ctrl_bits_q >> 1;
							bits_left_q <= left_nx;
							phase_q     <= phase_after_bit;
						end else begin
							off_lo_q <= in_byte;
							phase_q  <= PH_LEN;
						end
					end
					PH_LEN: begin
						pend_s1     <= 1'b1;
						lit_s1      <= 1'b0;
						fwd_s1      <= fwd_nx;
						remain_q    <= match_cnt;
						src_q       <= match_off + AW'(1);
						ctrl_bits_q <= ctrl_bits_q >> 1;
						bits_left_q <= left_nx;
						phase_q     <= phase_after_bit;
					end
					default: begin
						ctrl_bits_q <= in_byte;
						bits_left_q <= 4'(FlagBits);
						phase_q     <= PH_DATA;
					end
				endcase
			end

			// one byte out and into the window
			if (emit_go) begin
				wp_q     <= wp_q + AW'(1);
				count_q  <= count_nx;
				remain_q <= remain_q - RunW'(1);
				if (hit_end) begin
					finished_q <= 1'b1;
				end
				if (more) begin
					src_q  <= src_q + AW'(1);
					fwd_s1 <= fwd_nx;
				end else begin
					pend_s1 <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== src/lzss_window_decompressor.sv =====
// lzss decompressor top level with 4k history window and output register
//
//   channel  | signals                               | direction
//   ---------+---------------------------------------+----------
//   config   | cfg_valid, cfg_ready, out_length[23:0] | in
//   input    | in_valid, in_ready, in_byte[7:0]       | in
//   output   | out_valid, out_ready, out_byte, last   | out
//
// flag and offset bytes only update the parser; a literal or length byte holds
// in_ready low until its bytes are out, copied one byte per cycle from the
// window memory while the output slot is free, forwarding a read that hits
// the entry written in the same cycle. after reset and after every out_length
// write the window is cleared, one entry a cycle, during which in_ready is low.
// a stalled output register holds the sequencer; the next input byte is taken
// while the last result still waits in the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lzss_window_decompressor import lzd_pkg::*; #(
	parameter int WINDOW_DEPTH = WindowDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LenW-1:0]  out_length,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [ByteW-1:0] in_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ByteW-1:0] out_byte,
	output logic             last
);

	lzd_emit_t        emit;
	lzd_stat_t        stat;
	logic             slot_free;
	logic             cfg_xfer;
	logic             out_valid_q;
	logic [ByteW-1:0] out_byte_q;
	logic             last_q;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;

	// output slot can take a byte when empty or being drained
	assign slot_free = !out_valid_q || out_ready;

	lzd_ctrl #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_xfer),
		.out_length (out_length),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.slot_free  (slot_free),
		.emit       (emit),
		.stat       (stat)
	);

	// output register payload
	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_byte_q <= emit.data;
			last_q     <= emit.last;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	// checks
	`LZD_ASSERT_IMP(a_emit_needs_slot, clk, arst_n, emit.valid, slot_free)
	`LZD_ASSERT_IMP(a_quiet_when_idle, clk, arst_n, stat.clearing || stat.finished, !emit.valid)
	`LZD_ASSERT_NEXT(a_cfg_starts_clear, clk, arst_n, cfg_xfer, stat.clearing && !in_ready)
	`LZD_ASSERT_NEXT(a_nothing_after_last, clk, arst_n, emit.valid && emit.last, !emit.valid)

endmodule
